### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL of the mutual exclusion node.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RAMN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ramn: property violated");

// Checks that a condition never holds on a rising clock edge outside reset.
`define RAMN_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ramn: forbidden condition observed");

`endif

### hw/rtl/ramn_pkg.sv
`default_nettype none

package ramn_pkg;

   localparam int MAX_NODES_DEFAULT  = 16;
   localparam int CLOCK_BITS_DEFAULT = 32;

   localparam int RANK_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int STAMP_W  = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;

   localparam logic [RANK_W-1:0]  OWN_RANK_RESET   = 4'd0;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd2;

   typedef enum logic [1:0] {
      OP_REQUEST  = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_PEER_REQ = 2'd2,
      OP_PEER_ACK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_GRANT   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_REQ  = 2'd1,
      PH_CS   = 2'd2
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_RANK   = 4'd0,
      CSR_NODE_COUNT = 4'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_TICK,
      ST_ACK_TICK,
      ST_EMIT_ACK,
      ST_GRANT,
      ST_REQ_WALK,
      ST_REL_WALK
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/ricart_agrawala_mutex_node_unit.sv
// One node of Ricart-Agrawala mutual exclusion with a saturating Lamport clock. Each
// transaction on req_ is one event (request entry, release, peer request, peer
// acknowledgement); the node answers with zero or more transactions on rsp_, the final one
// marked by rsp_tlast. A single saturating max/increment unit updates the logical clock
// under a small sequencer, so the node takes one event at a time. A peer request is
// deferred or acknowledged at once, and a request or release walks the ranks (up to the
// effective node count), producing at most one message per cycle while rsp_tready does
// not hold off a waiting message; a request with no peers is granted at once.
// Configuration writes on csr_ are taken at any time but belong in idle gaps.
`default_nettype none
`include "assert_macros.svh"

module ricart_agrawala_mutex_node_unit #(
   parameter int MAX_NODES  = ramn_pkg::MAX_NODES_DEFAULT,
   parameter int CLOCK_BITS = ramn_pkg::CLOCK_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: peer (4), peer_stamp (32), zero fill (4).
   input  wire logic [ramn_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields from bit 0: operation (2).
   input  wire logic [1:0]                         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // Fields from bit 0: target (4), stamp (32), zero fill (4).
   output logic [ramn_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // Fields from bit 0: out_kind (2).
   output logic [1:0]                              rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ramn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ramn_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int KW = (NW > ramn_pkg::COUNT_W) ? NW : ramn_pkg::COUNT_W;
   localparam int CB = CLOCK_BITS;
   localparam int XW = (CB > ramn_pkg::STAMP_W) ? CB : ramn_pkg::STAMP_W;
   localparam logic [XW-1:0] CLOCK_MAX_X = XW'({CB{1'b1}});

   // Architectural state.
   logic [CB-1:0]                     clock_ff, clock_in;
   logic [CB-1:0]                     req_stamp_ff, req_stamp_in;
   ramn_pkg::phase_type               phase_ff, phase_in;
   logic [NW-1:0]                     ack_ff, ack_in;
   logic [MAX_NODES-1:0]              deferred_ff, deferred_in;
   logic [ramn_pkg::RANK_W-1:0]       own_rank_ff, own_rank_in;
   logic [ramn_pkg::COUNT_W-1:0]      node_count_ff, node_count_in;

   // Sequencer and the event being worked on.
   ramn_pkg::state_type               state_ff, state_in;
   ramn_pkg::op_type                  op_ff, op_in;
   logic [ramn_pkg::RANK_W-1:0]       peer_ff, peer_in;
   logic [ramn_pkg::STAMP_W-1:0]      pst_ff, pst_in;
   logic [IW-1:0]                     idx_ff, idx_in;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   ramn_pkg::kind_type                rsp_kind_ff, rsp_kind_in;
   logic [ramn_pkg::RANK_W-1:0]       rsp_target_ff, rsp_target_in;
   logic [ramn_pkg::STAMP_W-1:0]      rsp_stamp_ff, rsp_stamp_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_load;
   logic                              slot_free;

   // Derived values.
   logic [NW-1:0]                     n_eff;
   logic [NW-1:0]                     peer_total;
   logic [KW-1:0]                     n_k, own_k, peer_k, idx_k, in_peer_k, last_peer_k;
   logic                              in_is_peer;
   logic                              mine_first;
   logic [NW-1:0]                     ack_next;
   logic [MAX_NODES-1:0]              below_n, above_idx;
   logic                              rel_last;

   // Shared clock unit: saturating max-merge or saturating increment.
   logic [XW-1:0]                     clk_x, pst_x, max_x;
   logic [CB-1:0]                     unit_merge, unit_inc;

   always_comb begin
      clk_x = XW'(clock_ff);
      pst_x = XW'(pst_ff);
      max_x = (clk_x > pst_x) ? clk_x : pst_x;
      if (max_x > CLOCK_MAX_X) begin
         max_x = CLOCK_MAX_X;
      end
      unit_merge = max_x[CB-1:0];
      unit_inc   = (clock_ff == {CB{1'b1}}) ? clock_ff : clock_ff + CB'(1);
   end

   always_comb begin
      if (KW'(node_count_ff) > KW'(MAX_NODES)) begin
         n_eff = NW'(MAX_NODES);
      end else begin
         n_eff = NW'(node_count_ff);
      end
      n_k        = KW'(n_eff);
      own_k      = KW'(own_rank_ff);
      peer_k     = KW'(peer_ff);
      idx_k      = KW'(idx_ff);
      in_peer_k  = KW'(req_tdata[ramn_pkg::RANK_W-1:0]);
      peer_total = (n_k > own_k) ? n_eff - NW'(1) : n_eff;
      in_is_peer = (in_peer_k < n_k) && (in_peer_k != own_k);
      // When this node holds the top rank, the last peer sits just below it.
      last_peer_k = (own_k == n_k - KW'(1)) ? n_k - KW'(2) : n_k - KW'(1);
      mine_first = (XW'(req_stamp_ff) < pst_x) ||
                   ((XW'(req_stamp_ff) == pst_x) && (own_k < peer_k));
      ack_next   = ack_ff + NW'(1);
      for (int j = 0; j < MAX_NODES; j++) begin
         below_n[j]   = KW'(j) < n_k;
         above_idx[j] = KW'(j) > idx_k;
      end
      rel_last  = (deferred_ff & below_n & above_idx) == '0;
      slot_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      clock_in      = clock_ff;
      req_stamp_in  = req_stamp_ff;
      phase_in      = phase_ff;
      ack_in        = ack_ff;
      deferred_in   = deferred_ff;
      own_rank_in   = own_rank_ff;
      node_count_in = node_count_ff;
      state_in      = state_ff;
      op_in         = op_ff;
      peer_in       = peer_ff;
      pst_in        = pst_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_target_in = rsp_target_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = 1'b0;
      csr_ready     = 1'b1;

      if (csr_valid) begin
         if (csr_index == ramn_pkg::CSR_OWN_RANK) begin
            own_rank_in = csr_data[ramn_pkg::RANK_W-1:0];
         end else if (csr_index == ramn_pkg::CSR_NODE_COUNT) begin
            node_count_in = csr_data[ramn_pkg::COUNT_W-1:0];
         end
      end

      unique case (state_ff)
         ramn_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = ramn_pkg::op_type'(req_tuser);
               peer_in = req_tdata[ramn_pkg::RANK_W-1:0];
               pst_in  = req_tdata[ramn_pkg::RANK_W +: ramn_pkg::STAMP_W];
               unique case (ramn_pkg::op_type'(req_tuser))
                  ramn_pkg::OP_REQUEST: begin
                     if (phase_ff == ramn_pkg::PH_IDLE) begin
                        state_in = ramn_pkg::ST_TICK;
                     end
                  end
                  ramn_pkg::OP_RELEASE: begin
                     if (phase_ff == ramn_pkg::PH_CS) begin
                        state_in = ramn_pkg::ST_TICK;
                     end
                  end
                  ramn_pkg::OP_PEER_REQ, ramn_pkg::OP_PEER_ACK: begin
                     // A message from a rank outside the peer set is dropped silently.
                     if (in_is_peer) begin
                        state_in = ramn_pkg::ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ramn_pkg::ST_MERGE: begin
            clock_in = unit_merge;
            state_in = ramn_pkg::ST_TICK;
         end
         ramn_pkg::ST_TICK: begin
            clock_in = unit_inc;
            state_in = ramn_pkg::ST_IDLE;
            unique case (op_ff)
               ramn_pkg::OP_REQUEST: begin
                  req_stamp_in = unit_inc;
                  ack_in       = '0;
                  phase_in     = ramn_pkg::PH_REQ;
                  idx_in       = '0;
                  if (peer_total == '0) begin
                     phase_in = ramn_pkg::PH_CS;
                     state_in = ramn_pkg::ST_GRANT;
                  end else begin
                     state_in = ramn_pkg::ST_REQ_WALK;
                  end
               end
               ramn_pkg::OP_RELEASE: begin
                  idx_in = '0;
                  if (n_eff == '0) begin
                     deferred_in = '0;
                     phase_in    = ramn_pkg::PH_IDLE;
                  end else begin
                     state_in = ramn_pkg::ST_REL_WALK;
                  end
               end
               ramn_pkg::OP_PEER_REQ: begin
                  if ((phase_ff == ramn_pkg::PH_CS) ||
                      ((phase_ff == ramn_pkg::PH_REQ) && mine_first)) begin
                     deferred_in[peer_k[IW-1:0]] = 1'b1;
                  end else begin
                     state_in = ramn_pkg::ST_ACK_TICK;
                  end
               end
               ramn_pkg::OP_PEER_ACK: begin
                  // Acknowledgements outside a request only move the clock.
                  if (phase_ff == ramn_pkg::PH_REQ) begin
                     ack_in = ack_next;
                     if (ack_next >= peer_total) begin
                        phase_in = ramn_pkg::PH_CS;
                        state_in = ramn_pkg::ST_GRANT;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ramn_pkg::ST_ACK_TICK: begin
            clock_in = unit_inc;
            state_in = ramn_pkg::ST_EMIT_ACK;
         end
         ramn_pkg::ST_EMIT_ACK: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = ramn_pkg::KIND_ACK;
               rsp_target_in = peer_ff;
               rsp_stamp_in  = clk_x[ramn_pkg::STAMP_W-1:0];
               rsp_last_in   = 1'b1;
               state_in      = ramn_pkg::ST_IDLE;
            end
         end
         ramn_pkg::ST_GRANT: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = ramn_pkg::KIND_GRANT;
               rsp_target_in = own_rank_ff;
               rsp_stamp_in  = clk_x[ramn_pkg::STAMP_W-1:0];
               rsp_last_in   = 1'b1;
               state_in      = ramn_pkg::ST_IDLE;
            end
         end
         ramn_pkg::ST_REQ_WALK: begin
            // Own rank is stepped over without a message.
            if ((idx_k == own_k) || slot_free) begin
               if (idx_k != own_k) begin
                  rsp_load      = 1'b1;
                  rsp_kind_in   = ramn_pkg::KIND_REQUEST;
                  rsp_target_in = idx_k[ramn_pkg::RANK_W-1:0];
                  rsp_stamp_in  = clk_x[ramn_pkg::STAMP_W-1:0];
                  rsp_last_in   = idx_k == last_peer_k;
               end
               if (idx_k == last_peer_k) begin
                  state_in = ramn_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ramn_pkg::ST_REL_WALK: begin
            if (!deferred_ff[idx_ff] || slot_free) begin
               if (deferred_ff[idx_ff]) begin
                  rsp_load      = 1'b1;
                  rsp_kind_in   = ramn_pkg::KIND_ACK;
                  rsp_target_in = idx_k[ramn_pkg::RANK_W-1:0];
                  rsp_stamp_in  = clk_x[ramn_pkg::STAMP_W-1:0];
                  rsp_last_in   = rel_last;
               end
               if ((deferred_ff[idx_ff] && rel_last) || (idx_k == n_k - KW'(1))) begin
                  deferred_in = '0;
                  phase_in    = ramn_pkg::PH_IDLE;
                  state_in    = ramn_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ramn_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff      <= '0;
         req_stamp_ff  <= '0;
         phase_ff      <= ramn_pkg::PH_IDLE;
         ack_ff        <= '0;
         deferred_ff   <= '0;
         own_rank_ff   <= ramn_pkg::OWN_RANK_RESET;
         node_count_ff <= ramn_pkg::NODE_COUNT_RESET;
         state_ff      <= ramn_pkg::ST_IDLE;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clock_ff      <= clock_in;
         req_stamp_ff  <= req_stamp_in;
         phase_ff      <= phase_in;
         ack_ff        <= ack_in;
         deferred_ff   <= deferred_in;
         own_rank_ff   <= own_rank_in;
         node_count_ff <= node_count_in;
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      peer_ff       <= peer_in;
      pst_ff        <= pst_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_target_ff <= rsp_target_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(ramn_pkg::RSP_DATA_W - ramn_pkg::STAMP_W - ramn_pkg::RANK_W){1'b0}},
                        rsp_stamp_ff, rsp_target_ff};

   `RAMN_ASSERT(a_idle_no_deferred, clock, reset, (phase_ff == ramn_pkg::PH_IDLE) |-> (deferred_ff == '0))
   `RAMN_ASSERT(a_last_ends_event, clock, reset, (rsp_load && rsp_last_in) |=> (state_ff == ramn_pkg::ST_IDLE))
   `RAMN_ASSERT(a_walk_requesting, clock, reset, (state_ff == ramn_pkg::ST_REQ_WALK) |-> (phase_ff == ramn_pkg::PH_REQ))
   `RAMN_ASSERT_NEVER(a_busy_no_accept, clock, reset, req_tready && (state_ff != ramn_pkg::ST_IDLE))

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int BY_MODEL = -1;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      ramn_pkg::kind_type kind;
      logic [3:0]         target;
      logic [31:0]        stamp;
      logic               last;
   } msg_type;

   typedef struct {
      bit                      is_cfg;
      ramn_pkg::csr_index_type reg_id;
      logic [4:0]              value;
      ramn_pkg::op_type        op;
      logic [3:0]              peer;
      logic [31:0]             stamp;
      int                      typed;
      ramn_pkg::kind_type      kind;
      logic [3:0]              target;
      logic [31:0]             exp_stamp;
   } plan_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [ramn_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic [1:0]                       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [ramn_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [ramn_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ramn_pkg::CSR_DATA_W-1:0]  csr_data;

   ricart_agrawala_mutex_node_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Mirror of the node: configuration, Lamport clock and protocol state.
   logic [3:0]          cfg_rank  = ramn_pkg::OWN_RANK_RESET;
   logic [4:0]          cfg_count = ramn_pkg::NODE_COUNT_RESET;
   logic [31:0]         lclock    = '0;
   logic [31:0]         req_stamp = '0;
   ramn_pkg::phase_type phase     = ramn_pkg::PH_IDLE;
   int                  acks      = 0;
   logic [15:0]         deferred  = '0;

   msg_type step_msgs[$];
   msg_type pending_msgs[$];
   int      errors = 0;

   // Set by the sender together with the data it offers.
   int      cur_typed = BY_MODEL;
   msg_type cur_typed_msg;

   int snd_idle = 7;
   int rcv_idle = 45;
   int hold_left = 0;

   plan_row_type plan [27] = '{
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_RELEASE, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_ACK, 4'd1, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd0, '1,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd15, '1,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        1, ramn_pkg::KIND_REQUEST, 4'd1, 32'd2},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd1, 32'd2,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_ACK, 4'd1, 32'd0,
        1, ramn_pkg::KIND_GRANT, 4'd0, 32'd4},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd1, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_RELEASE, 4'd0, 32'd0,
        1, ramn_pkg::KIND_ACK, 4'd1, 32'd6},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_RELEASE, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b1, ramn_pkg::CSR_OWN_RANK, 5'd1, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        1, ramn_pkg::KIND_REQUEST, 4'd0, 32'd7},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd0, 32'd7,
        1, ramn_pkg::KIND_ACK, 4'd0, 32'd9},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd0, 32'd8,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_ACK, 4'd0, 32'd20,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_RELEASE, 4'd0, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b1, ramn_pkg::CSR_NODE_COUNT, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd0, 32'd5,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_RELEASE, 4'd0, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b1, ramn_pkg::CSR_OWN_RANK, 5'd15, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b1, ramn_pkg::CSR_NODE_COUNT, 5'd16, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        0, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_REQUEST, 4'd0, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd3, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_REQ, 4'd14, 32'hFFFF,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0},
      '{1'b0, ramn_pkg::CSR_OWN_RANK, 5'd0, ramn_pkg::OP_PEER_ACK, 4'd6, 32'd0,
        BY_MODEL, ramn_pkg::KIND_ACK, 4'd0, 32'd0}
   };

   logic [3:0] blk_rank  [6] = '{4'd3, 4'd15, 4'd0, 4'd9, 4'd7, 4'd5};
   logic [4:0] blk_count [6] = '{5'd5, 5'd16, 5'd1, 5'd31, 5'd4, 5'd12};
   int         blk_items [6] = '{80, 80, 30, 80, 80, 80};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int live_nodes();
      return (cfg_count > 5'd16) ? 16 : int'(cfg_count);
   endfunction

   function automatic int peer_total();
      return (live_nodes() > int'(cfg_rank)) ? live_nodes() - 1 : live_nodes();
   endfunction

   function automatic bit is_peer(logic [3:0] r);
      return int'(r) < live_nodes() && r != cfg_rank;
   endfunction

   function automatic logic [31:0] tick(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic void emit(ramn_pkg::kind_type k, logic [3:0] t, logic [31:0] s);
      step_msgs.push_back(msg_type'{k, t, s, 1'b0});
   endfunction

   // Advances the mirrored node by one event and leaves the messages it sends in step_msgs.
   function automatic void node_step(ramn_pkg::op_type op, logic [3:0] peer,
                                     logic [31:0] pst);
      int  n;
      bit  mine_first;
      n = live_nodes();
      step_msgs.delete();
      case (op)
         ramn_pkg::OP_REQUEST: begin
            if (phase == ramn_pkg::PH_IDLE) begin
               lclock = tick(lclock);
               req_stamp = lclock;
               acks = 0;
               phase = ramn_pkg::PH_REQ;
               for (int i = 0; i < n; i++)
                  if (4'(i) != cfg_rank) emit(ramn_pkg::KIND_REQUEST, 4'(i), lclock);
               if (peer_total() == 0) begin
                  phase = ramn_pkg::PH_CS;
                  emit(ramn_pkg::KIND_GRANT, cfg_rank, lclock);
               end
            end
         end
         ramn_pkg::OP_RELEASE: begin
            if (phase == ramn_pkg::PH_CS) begin
               lclock = tick(lclock);
               for (int i = 0; i < n; i++)
                  if (deferred[i]) emit(ramn_pkg::KIND_ACK, 4'(i), lclock);
               deferred = '0;
               phase = ramn_pkg::PH_IDLE;
            end
         end
         default: begin
            if (is_peer(peer)) begin
               lclock = tick((pst > lclock) ? pst : lclock);
               if (op == ramn_pkg::OP_PEER_REQ) begin
                  // The lower (stamp, rank) pair wins; a tie on stamps goes to the lower rank.
                  mine_first = req_stamp < pst || (req_stamp == pst && cfg_rank < peer);
                  if (phase == ramn_pkg::PH_CS ||
                      (phase == ramn_pkg::PH_REQ && mine_first)) begin
                     deferred[peer] = 1'b1;
                  end else begin
                     lclock = tick(lclock);
                     emit(ramn_pkg::KIND_ACK, peer, lclock);
                  end
               end else if (phase == ramn_pkg::PH_REQ) begin
                  acks++;
                  if (acks >= peer_total()) begin
                     phase = ramn_pkg::PH_CS;
                     emit(ramn_pkg::KIND_GRANT, cfg_rank, lclock);
                  end
               end
            end
         end
      endcase
      if (step_msgs.size() > 0) step_msgs[step_msgs.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      msg_type got;
      msg_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ramn_pkg::CSR_OWN_RANK:   cfg_rank = csr_data[3:0];
               ramn_pkg::CSR_NODE_COUNT: cfg_count = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            node_step(ramn_pkg::op_type'(req_tuser), req_tdata[3:0], req_tdata[35:4]);
            if (cur_typed == BY_MODEL) begin
               foreach (step_msgs[i]) pending_msgs.push_back(step_msgs[i]);
            end else if (cur_typed == 1) begin
               pending_msgs.push_back(cur_typed_msg);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = msg_type'{ramn_pkg::kind_type'(rsp_tuser), rsp_tdata[3:0], rsp_tdata[35:4],
                            rsp_tlast};
            if (pending_msgs.size() == 0) begin
               $error("unexpected result: kind %0d target %0d stamp %0d last %0d",
                      got.kind, got.target, got.stamp, got.last);
               errors++;
            end else begin
               want = pending_msgs.pop_front();
               compare_field("out_kind", 32'(want.kind), 32'(got.kind));
               compare_field("target", 32'(want.target), 32'(got.target));
               compare_field("stamp", want.stamp, got.stamp);
               compare_field("last", 32'(want.last), 32'(got.last));
            end
         end
      end
   end

   // Receiver: random back-pressure, or a long hold-off while hold_left runs down.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left <= hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [3:0] any_peer();
      logic [3:0] r;
      if (peer_total() == 0) return 4'($urandom_range(15));
      do r = 4'($urandom_range(live_nodes() - 1)); while (r == cfg_rank);
      return r;
   endfunction

   function automatic logic [3:0] stranger();
      if (live_nodes() < 16 && $urandom_range(1) == 1)
         return 4'($urandom_range(15, live_nodes()));
      return cfg_rank;
   endfunction

   function automatic logic [31:0] near(logic [31:0] base);
      longint v;
      int     off;
      off = int'($urandom_range(6)) - 3;
      v = longint'(base) + off;
      if (v < 0) v = 0;
      if (v > longint'(32'hFFFF_FFFF)) v = longint'(32'hFFFF_FFFF);
      return v[31:0];
   endfunction

   // Stamps cluster around the request stamp and the clock, so ties are frequent.
   function automatic logic [31:0] pick_stamp();
      int r;
      r = $urandom_range(99);
      if (r < 3) return $urandom();
      if (r < 45) return near(req_stamp);
      return near(lclock);
   endfunction

   task automatic pick_event(output ramn_pkg::op_type op, output logic [3:0] peer,
                             output logic [31:0] st);
      int r;
      r = $urandom_range(99);
      peer = any_peer();
      st = pick_stamp();
      if (r < 10) begin
         op = ramn_pkg::op_type'($urandom_range(3));
         peer = stranger();
         st = $urandom();
      end else begin
         case (phase)
            ramn_pkg::PH_IDLE:
               op = (r < 45) ? ramn_pkg::OP_REQUEST : (r < 75) ? ramn_pkg::OP_PEER_REQ :
                    (r < 88) ? ramn_pkg::OP_PEER_ACK : ramn_pkg::OP_RELEASE;
            ramn_pkg::PH_REQ:
               op = (r < 55) ? ramn_pkg::OP_PEER_ACK : (r < 85) ? ramn_pkg::OP_PEER_REQ :
                    (r < 93) ? ramn_pkg::OP_REQUEST : ramn_pkg::OP_RELEASE;
            default:
               op = (r < 45) ? ramn_pkg::OP_RELEASE : (r < 80) ? ramn_pkg::OP_PEER_REQ :
                    (r < 90) ? ramn_pkg::OP_PEER_ACK : ramn_pkg::OP_REQUEST;
         endcase
      end
   endtask

   // All sender tasks start and end at a falling edge.
   task automatic put_event(ramn_pkg::op_type op, logic [3:0] peer, logic [31:0] st,
                            int typed, msg_type typed_msg);
      cur_typed = typed;
      cur_typed_msg = typed_msg;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, st, peer};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Waits until every owed message is out and the node has finished silent events.
   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      while (pending_msgs.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(ramn_pkg::csr_index_type idx, logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      ramn_pkg::op_type op;
      logic [3:0]       peer;
      logic [31:0]      st;
      msg_type          none;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      none = msg_type'{ramn_pkg::KIND_ACK, 4'd0, 32'd0, 1'b0};
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            drain(SETTLE_CYCLES);
            csr_write(plan[i].reg_id, plan[i].value);
         end else begin
            sender_gap();
            put_event(plan[i].op, plan[i].peer, plan[i].stamp, plan[i].typed,
                      msg_type'{plan[i].kind, plan[i].target, plan[i].exp_stamp, 1'b1});
         end
      end

      for (int b = 0; b < 6; b++) begin
         drain(SETTLE_CYCLES);
         case (b / 2)
            0: begin snd_idle = 7; rcv_idle = 45; end
            1: begin snd_idle = 45; rcv_idle = 7; end
            default: begin snd_idle = 0; rcv_idle = 0; end
         endcase
         csr_write(ramn_pkg::CSR_OWN_RANK, 5'(blk_rank[b]));
         csr_write(ramn_pkg::CSR_NODE_COUNT, blk_count[b]);
         for (int k = 0; k < blk_items[b]; k++) begin
            if (b == 0 && k == 30) hold_left <= 300;
            if (b == 1 && k == 40) drain(1);
            sender_gap();
            pick_event(op, peer, st);
            // Late in the run the clock is pushed into saturation and stays there.
            if (b == 5 && k == 40 && peer_total() > 0) begin
               op = ramn_pkg::OP_PEER_ACK;
               peer = any_peer();
               st = 32'hFFFF_FFFE;
            end
            put_event(op, peer, st, BY_MODEL, none);
         end
      end

      drain(SETTLE_CYCLES);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
